@@ rtl/scsu_pkg.sv @@
// Shared constants and types of the SCSU text encoder.
package scsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    // SCSU tag bytes.
    localparam logic [7:0] TAG_SQ0 = 8'h01;
    localparam logic [7:0] TAG_SQU = 8'h0E;
    localparam logic [7:0] TAG_SCU = 8'h0F;
    localparam logic [7:0] TAG_SC0 = 8'h10;
    localparam logic [7:0] TAG_UC0 = 8'hE0;
    localparam logic [7:0] TAG_UQU = 8'hF0;

    // C0 codes that pass unquoted: NUL, TAB, LF, CR.
    localparam logic [31:0] PASS_MASK = 32'h0000_2601;

    localparam logic [15:0] BOM_CODE = 16'hFEFF;
    localparam logic [15:0] PUA_LOW  = 16'hE000;
    localparam logic [15:0] PUA_HIGH = 16'hF2FF;

    // Window offsets; element 0 is the rightmost entry.
    localparam logic [7:0][15:0] DYN_BASE = {
        16'hFF00, 16'h30A0, 16'h3040, 16'h0900,
        16'h0600, 16'h0400, 16'h00C0, 16'h0080
    };
    localparam logic [7:0][15:0] STAT_BASE = {
        16'h3000, 16'h2100, 16'h2080, 16'h2000,
        16'h0300, 16'h0100, 16'h0080, 16'h0000
    };

    // Encoded bytes of one code unit; last_idx is the number of bytes minus one.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } scsu_rec_t;

    typedef struct packed {
        logic       unicode_mode;
        logic [2:0] active_window;
    } scsu_state_t;

endpackage

@@ rtl/scsu_front.sv @@
// Front end: classifies each code unit, builds its byte record and tracks the encoder state.
module scsu_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [15:0]             code_unit,
    input  logic                    end_of_text,
    input  logic                    accept,
    output scsu_pkg::scsu_rec_t     rec,
    output scsu_pkg::scsu_state_t   state
);
    import scsu_pkg::*;

    logic            mode_reg, mode_next;
    logic [2:0]      win_reg, win_next;
    logic [7:0][15:0] ddiff, sdiff;
    logic [7:0]      dm, sm;
    logic [2:0]      dw, sw;
    logic            ascii, ascii_tag, priv;
    logic [7:0]      b_cur, b_dyn, b_stat, b_sc, b_sq, b_uc_cur, b_uc_new;
    logic [7:0]      hi, lo;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ddiff[i] = code_unit - DYN_BASE[i];
            sdiff[i] = code_unit - STAT_BASE[i];
            dm[i]    = (ddiff[i][15:7] == 9'd0);
            sm[i]    = (sdiff[i][15:7] == 9'd0);
        end
        // First matching window wins.
        dw = 3'd0;
        sw = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (dm[i])
            begin
                dw = 3'(i);
            end
            if (sm[i])
            begin
                sw = 3'(i);
            end
        end
    end

    assign ascii     = (code_unit[15:7] == 9'd0);
    assign ascii_tag = ascii && (code_unit[6:5] == 2'b00) && !PASS_MASK[code_unit[4:0]];
    assign priv      = (code_unit >= PUA_LOW) && (code_unit <= PUA_HIGH);
    assign hi        = code_unit[15:8];
    assign lo        = code_unit[7:0];
    assign b_cur     = {1'b1, ddiff[win_reg][6:0]};
    assign b_dyn     = {1'b1, ddiff[dw][6:0]};
    assign b_stat    = {1'b0, sdiff[sw][6:0]};
    assign b_sc      = TAG_SC0 + {5'd0, dw};
    assign b_sq      = TAG_SQ0 + {5'd0, sw};
    assign b_uc_cur  = TAG_UC0 + {5'd0, win_reg};
    assign b_uc_new  = TAG_UC0 + {5'd0, dw};

    always_comb
    begin
        rec       = '0;
        mode_next = mode_reg;
        win_next  = win_reg;
        if (!mode_reg)
        begin
            if (ascii)
            begin
                if (ascii_tag)
                begin
                    rec.bytes[0] = TAG_SQ0;
                    rec.bytes[1] = lo;
                    rec.last_idx = 2'd1;
                end
                else
                begin
                    rec.bytes[0] = lo;
                    rec.last_idx = 2'd0;
                end
            end
            else if (dm[win_reg])
            begin
                rec.bytes[0] = b_cur;
                rec.last_idx = 2'd0;
            end
            else if (|dm)
            begin
                rec.bytes[0] = b_sc;
                rec.bytes[1] = b_dyn;
                rec.last_idx = 2'd1;
                win_next     = dw;
            end
            else if (|sm)
            begin
                rec.bytes[0] = b_sq;
                rec.bytes[1] = b_stat;
                rec.last_idx = 2'd1;
            end
            else if (code_unit == BOM_CODE)
            begin
                rec.bytes[0] = TAG_SQU;
                rec.bytes[1] = hi;
                rec.bytes[2] = lo;
                rec.last_idx = 2'd2;
            end
            else
            begin
                mode_next    = 1'b1;
                rec.bytes[0] = TAG_SCU;
                if (priv)
                begin
                    rec.bytes[1] = TAG_UQU;
                    rec.bytes[2] = hi;
                    rec.bytes[3] = lo;
                    rec.last_idx = 2'd3;
                end
                else
                begin
                    rec.bytes[1] = hi;
                    rec.bytes[2] = lo;
                    rec.last_idx = 2'd2;
                end
            end
        end
        else
        begin
            if (ascii)
            begin
                mode_next    = 1'b0;
                rec.bytes[0] = b_uc_cur;
                if (ascii_tag)
                begin
                    rec.bytes[1] = TAG_SQ0;
                    rec.bytes[2] = lo;
                    rec.last_idx = 2'd2;
                end
                else
                begin
                    rec.bytes[1] = lo;
                    rec.last_idx = 2'd1;
                end
            end
            else if (|dm)
            begin
                mode_next    = 1'b0;
                win_next     = dw;
                rec.bytes[0] = b_uc_new;
                rec.bytes[1] = b_dyn;
                rec.last_idx = 2'd1;
            end
            else if (priv)
            begin
                rec.bytes[0] = TAG_UQU;
                rec.bytes[1] = hi;
                rec.bytes[2] = lo;
                rec.last_idx = 2'd2;
            end
            else
            begin
                rec.bytes[0] = hi;
                rec.bytes[1] = lo;
                rec.last_idx = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            win_reg  <= 3'd0;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                mode_reg <= 1'b0;
                win_reg  <= 3'd0;
            end
            else
            begin
                mode_reg <= mode_next;
                win_reg  <= win_next;
            end
        end
    end

    assign state.unicode_mode  = mode_reg;
    assign state.active_window = win_reg;

endmodule

@@ rtl/scsu_queue.sv @@
// Short queue of byte records between the front end and the serializer.
module scsu_queue #(
    parameter int DEPTH = scsu_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scsu_pkg::scsu_rec_t wr_rec,
    input  logic                pop,
    output scsu_pkg::scsu_rec_t rd_rec,
    output logic                full,
    output logic                empty
);
    import scsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scsu_rec_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_rec = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/scsu_back.sv @@
// Back end: sends the bytes of each queued record one per transfer through an output register.
module scsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  scsu_pkg::scsu_rec_t rd_rec,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_item
);
    import scsu_pkg::*;

    logic [1:0] idx_reg;
    logic       ovalid_reg;
    logic [7:0] obyte_reg;
    logic       olast_reg;
    logic       load, is_last;

    // The output register takes a new byte whenever a record is queued and the register is empty or being drained.
    assign load    = !empty && (!ovalid_reg || out_ready);
    assign is_last = (idx_reg == rd_rec.last_idx);
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ovalid_reg <= 1'b1;
                idx_reg    <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= rd_rec.bytes[idx_reg];
            olast_reg <= is_last;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_byte     = obyte_reg;
    assign last_of_item = olast_reg;

endmodule

@@ rtl/scsu_text_encoder_unit.sv @@
// SCSU text encoder, top level.
// Each accepted UTF-16 code unit is encoded in the cycle it is taken and leaves as one to
// four SCSU bytes, one byte per output transfer, the final one marked by last_of_item.
// A code unit is accepted every cycle while the record queue (QDEPTH entries) has room, so
// sustained throughput is one code unit per cycle for text that encodes to one byte per unit
// while out_ready is high; in general the byte serializer sets the rate at one output byte
// per cycle while out_ready is high. The first byte of a unit passes the record queue and
// then the output register. Mode and window state reset after a unit flagged end_of_text.
module scsu_text_encoder_unit #(
    parameter int QDEPTH = scsu_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_item
);
    import scsu_pkg::*;

    scsu_rec_t   front_rec, head_rec;
    scsu_state_t front_state;
    logic        accept, q_full, q_empty, q_pop;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    scsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .accept      (accept),
        .rec         (front_rec),
        .state       (front_state)
    );

    scsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .wr_rec (front_rec),
        .pop    (q_pop),
        .rd_rec (head_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    scsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_rec       (head_rec),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !q_full)
        else $error("record pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("record popped from an empty queue");

    a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=>
            (!front_state.unicode_mode && (front_state.active_window == 3'd0)))
        else $error("encoder state not reset after end of text");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last_of_item))
        else $error("record retired without a final byte");

endmodule
